// ----- src/i2cems_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults for the I2C EEPROM master sequencer.
// Used by the front, sequencer, output and top-level modules.
package i2cems_pkg;

  // Default tuning values
  localparam int unsigned DEF_BANK_SIZE   = 65536;
  localparam int unsigned DEF_PAGE_BYTES  = 128;
  localparam int unsigned DEF_RETRY_LIMIT = 200;
  localparam int unsigned DEF_MAX_LENGTH  = 1024;

  localparam logic [7:0] DEV_SEL_RESET = 8'hA6;

  // Request type codes
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // Bus actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;

  // TWI status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  typedef enum logic [1:0] {
    K_READ,
    K_WRITE,
    K_STATUS
  } kind_t;

  // Classified item passed from front to sequencer
  typedef struct packed {
    kind_t       kind;
    logic        len_bad;
    logic [16:0] address;
    logic [10:0] length;
    logic [7:0]  bus_status;
    logic [7:0]  bus_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  bus_action;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic        done_res;
    logic        failed;
    logic [10:0] byte_count;
  } result_t;

  // Results caused by one item: one or two
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  function automatic result_t mk_res(logic [2:0] act, logic [7:0] tx, logic [7:0] rxb,
                                     logic rxv, logic done, logic fail);
    result_t r;
    r.bus_action = act;
    r.tx_byte    = tx;
    r.rx_byte    = rxb;
    r.rx_valid   = rxv;
    r.done_res   = done;
    r.failed     = fail;
    r.byte_count = '0;
    return r;
  endfunction

endpackage

// ----- src/i2cems_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and queues them.
// Depends on i2cems_pkg.
module i2cems_front import i2cems_pkg::*; #(
  parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [16:0] address,
  input  logic [10:0] length,
  input  logic [7:0]  bus_status,
  input  logic [7:0]  bus_byte,
  input  logic [7:0]  write_byte,
  output logic        item_valid,
  input  logic        item_ready,
  output item_t       item
);

  localparam logic [16:0] MaxLen = 17'(MAX_LENGTH);

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  item_t      cls;
  logic       push, pop;

  // Classify the incoming item
  always_comb begin
    cls.kind       = (req_type == REQ_READ) ? K_READ :
                     (req_type == REQ_WRITE) ? K_WRITE : K_STATUS;
    cls.len_bad    = (length == '0) || ({6'd0, length} > MaxLen);
    cls.address    = address;
    cls.length     = length;
    cls.bus_status = bus_status;
    cls.bus_byte   = bus_byte;
    cls.write_byte = write_byte;
  end

  assign in_ready   = (cnt != 2'd2);
  // Drop the unused request code here
  assign push       = in_valid && in_ready && (req_type != 2'd3);
  assign pop        = item_valid && item_ready;
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/i2cems_seq.sv -----
`timescale 1ns / 1ps
// Back end: the transaction sequencer that turns items into bus actions.
// Depends on i2cems_pkg.
module i2cems_seq import i2cems_pkg::*; #(
  parameter int unsigned BANK_SIZE   = DEF_BANK_SIZE,
  parameter int unsigned PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int unsigned RETRY_LIMIT = DEF_RETRY_LIMIT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       bq_push,
  input  logic       bq_full,
  output bundle_t    bq_data
);

  // PAGE_BYTES must be a power of two
  localparam logic [16:0] Bank     = 17'(BANK_SIZE);
  localparam logic [16:0] PageMask = 17'(PAGE_BYTES - 1);
  localparam logic [9:0]  Page     = 10'(PAGE_BYTES);
  localparam logic [7:0]  Limit    = 8'(RETRY_LIMIT);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_SLA_W, PH_ADDR_HI, PH_ADDR_LO,
    PH_RSTART, PH_SLA_R, PH_RDATA, PH_WDATA
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  dev_sel;
  logic        is_write, is_write_next;
  logic [16:0] cur, cur_next;
  logic [10:0] rem, rem_next;
  logic [10:0] chunk, chunk_next;
  logic [7:0]  retry, retry_next;
  logic [10:0] done_cnt, done_cnt_next;

  logic        in_bank1;
  logic [16:0] offs;
  logic [7:0]  sla_w, sla_r;
  logic [10:0] chunk_calc;
  logic [9:0]  room;
  logic [17:0] rd_end;

  logic        take;
  logic        emit, two;
  result_t     r0, r1;

  // Bank, offset and select bytes
  assign in_bank1 = (cur >= Bank);
  assign offs     = in_bank1 ? (cur - Bank) : cur;
  assign sla_w    = {dev_sel[7:4], in_bank1, dev_sel[2:1], 1'b0};
  assign sla_r    = {dev_sel[7:4], in_bank1, dev_sel[2:1], 1'b1};

  // Part length: page room for writes, bank split for reads
  always_comb begin
    room   = Page - 10'(offs & PageMask);
    rd_end = {1'b0, cur} + {7'd0, rem};
    if (is_write) begin
      chunk_calc = ({1'b0, rem} > {1'b0, room}) ? 11'(room) : rem;
    end else if ((cur < Bank) && (rd_end > {1'b0, Bank})) begin
      chunk_calc = 11'(Bank - cur);
    end else begin
      chunk_calc = rem;
    end
  end

  assign item_ready = !bq_full;
  assign take       = item_valid && item_ready;

  // Next state and results
  always_comb begin
    logic        other, fail, do_end;
    logic [16:0] e_cur;
    logic [10:0] e_rem, e_chk;
    logic [7:0]  e_rxb;
    logic        e_rxv;
    logic [7:0]  st;
    logic [10:0] chk1;
    other         = 1'b0;
    fail          = 1'b0;
    do_end        = 1'b0;
    e_cur         = cur;
    e_rem         = rem;
    e_chk         = chunk;
    e_rxb         = '0;
    e_rxv         = 1'b0;
    st            = item.bus_status;
    chk1          = (chunk != '0) ? chunk - 11'd1 : chunk;
    phase_next    = phase;
    is_write_next = is_write;
    cur_next      = cur;
    rem_next      = rem;
    chunk_next    = chunk;
    retry_next    = retry;
    done_cnt_next = done_cnt;
    emit          = 1'b0;
    two           = 1'b0;
    r0            = '0;
    r1            = '0;

    if (take) begin
      if (item.kind != K_STATUS) begin
        if (phase == PH_IDLE) begin
          emit          = 1'b1;
          is_write_next = (item.kind == K_WRITE);
          cur_next      = item.address;
          done_cnt_next = '0;
          chunk_next    = '0;
          if (item.len_bad) begin
            rem_next   = '0;
            retry_next = '0;
            r0         = mk_res(ACT_NONE, '0, '0, 1'b0, 1'b1, 1'b1);
          end else begin
            rem_next   = item.length;
            retry_next = 8'd1;
            phase_next = PH_START;
            r0         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
          end
        end
      end else if (phase != PH_IDLE) begin
        emit = 1'b1;
        unique case (phase)
          PH_START: begin
            if (st == ST_START || st == ST_REP_START) begin
              chunk_next = chunk_calc;
              phase_next = PH_SLA_W;
              r0         = mk_res(ACT_SEND, sla_w, '0, 1'b0, 1'b0, 1'b0);
            end else if (st == ST_ARB_LOST) begin
              r0 = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
            end else begin
              phase_next = PH_IDLE;
              r0         = mk_res(ACT_NONE, '0, '0, 1'b0, 1'b1, 1'b1);
            end
          end
          PH_SLA_W: begin
            if (st == ST_MT_SLA_ACK) begin
              phase_next = PH_ADDR_HI;
              r0         = mk_res(ACT_SEND, offs[15:8], '0, 1'b0, 1'b0, 1'b0);
            end else if (st == ST_MT_SLA_NACK) begin
              if (retry >= Limit) begin
                fail = 1'b1;
              end else begin
                retry_next = retry + 8'd1;
                phase_next = PH_START;
                r0         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
              end
            end else begin
              other = 1'b1;
            end
          end
          PH_ADDR_HI: begin
            if (st == ST_MT_DATA_ACK) begin
              phase_next = PH_ADDR_LO;
              r0         = mk_res(ACT_SEND, offs[7:0], '0, 1'b0, 1'b0, 1'b0);
            end else if (st == ST_MT_DATA_NACK) begin
              if (is_write) begin
                fail = 1'b1;
              end else begin
                phase_next = PH_START;
                r0         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
              end
            end else begin
              other = 1'b1;
            end
          end
          PH_ADDR_LO: begin
            if (st == ST_MT_DATA_ACK) begin
              if (is_write) begin
                phase_next = PH_WDATA;
                r0         = mk_res(ACT_SEND, item.write_byte, '0, 1'b0, 1'b0, 1'b0);
              end else begin
                phase_next = PH_RSTART;
                r0         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
              end
            end else if (st == ST_MT_DATA_NACK) begin
              if (is_write) fail = 1'b1;
              else          do_end = 1'b1;
            end else begin
              other = 1'b1;
            end
          end
          PH_RSTART: begin
            if (st == ST_START || st == ST_REP_START) begin
              phase_next = PH_SLA_R;
              r0         = mk_res(ACT_SEND, sla_r, '0, 1'b0, 1'b0, 1'b0);
            end else begin
              other = 1'b1;
            end
          end
          PH_SLA_R: begin
            if (st == ST_MR_SLA_ACK) begin
              phase_next = PH_RDATA;
              r0 = mk_res((chunk > 11'd1) ? ACT_RX_ACK : ACT_RX_NACK,
                          '0, '0, 1'b0, 1'b0, 1'b0);
            end else if (st == ST_MR_SLA_NACK) begin
              do_end = 1'b1;
            end else begin
              other = 1'b1;
            end
          end
          PH_RDATA: begin
            if (st == ST_MR_DATA_ACK || st == ST_MR_DATA_NACK) begin
              done_cnt_next = done_cnt + 11'd1;
              e_cur         = cur + 17'd1;
              e_rem         = (rem != '0) ? rem - 11'd1 : rem;
              e_chk         = chk1;
              cur_next      = e_cur;
              rem_next      = e_rem;
              chunk_next    = chk1;
              if (st == ST_MR_DATA_NACK || chk1 == '0) begin
                do_end = 1'b1;
                e_rxb  = item.bus_byte;
                e_rxv  = 1'b1;
              end else begin
                r0 = mk_res((chk1 > 11'd1) ? ACT_RX_ACK : ACT_RX_NACK,
                            '0, item.bus_byte, 1'b1, 1'b0, 1'b0);
              end
            end else begin
              fail = 1'b1;
            end
          end
          PH_WDATA: begin
            if (st == ST_MT_DATA_ACK) begin
              done_cnt_next = done_cnt + 11'd1;
              e_cur         = cur + 17'd1;
              e_rem         = (rem != '0) ? rem - 11'd1 : rem;
              e_chk         = chk1;
              cur_next      = e_cur;
              rem_next      = e_rem;
              chunk_next    = chk1;
              if (chk1 == '0) begin
                do_end = 1'b1;
              end else begin
                r0 = mk_res(ACT_SEND, item.write_byte, '0, 1'b0, 1'b0, 1'b0);
              end
            end else begin
              fail = 1'b1;
            end
          end
          default: emit = 1'b0;
        endcase

        // Unexpected status: restart on arbitration loss, otherwise abort
        if (other) begin
          if (st == ST_ARB_LOST) begin
            phase_next = PH_START;
            r0         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
          end else begin
            fail = 1'b1;
          end
        end
        if (fail) begin
          phase_next = PH_IDLE;
          r0         = mk_res(ACT_STOP, '0, '0, 1'b0, 1'b1, 1'b1);
        end

        // End of a part: stop, then finish or open the next part
        if (do_end) begin
          cur_next   = e_cur + {6'd0, e_chk};
          rem_next   = e_rem - e_chk;
          chunk_next = '0;
          if (rem_next == '0) begin
            phase_next = PH_IDLE;
            r0         = mk_res(ACT_STOP, '0, e_rxb, e_rxv, 1'b1, 1'b0);
          end else begin
            two        = 1'b1;
            phase_next = PH_START;
            retry_next = 8'd1;
            r0         = mk_res(ACT_STOP, '0, e_rxb, e_rxv, 1'b0, 1'b0);
            r1         = mk_res(ACT_START, '0, '0, 1'b0, 1'b0, 1'b0);
          end
        end
      end
    end
    r0.byte_count = done_cnt_next;
    r1.byte_count = done_cnt_next;
  end

  assign bq_push    = emit;
  assign bq_data.two = two;
  assign bq_data.r0  = r0;
  assign bq_data.r1  = r1;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      dev_sel  <= DEV_SEL_RESET;
      is_write <= 1'b0;
      cur      <= '0;
      rem      <= '0;
      chunk    <= '0;
      retry    <= '0;
      done_cnt <= '0;
    end else begin
      if (cfg_wr_en) dev_sel <= cfg_wr_data;
      phase    <= phase_next;
      is_write <= is_write_next;
      cur      <= cur_next;
      rem      <= rem_next;
      chunk    <= chunk_next;
      retry    <= retry_next;
      done_cnt <= done_cnt_next;
    end
  end

endmodule

// ----- src/i2cems_out.sv -----
`timescale 1ns / 1ps
// Output stage: queues result bundles and sends them one result per transfer.
// Depends on i2cems_pkg.
module i2cems_out import i2cems_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    bq_push,
  output logic    bq_full,
  input  bundle_t bq_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res,
  output logic    res_last
);

  bundle_t    q [2];
  logic       wp, rp, idx;
  logic [1:0] cnt;
  bundle_t    head;
  logic       xfer, pop;

  assign head      = q[rp];
  assign bq_full   = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign res       = idx ? head.r1 : head.r0;
  assign res_last  = (idx == head.two);
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && res_last;

  // Hold queued bundles
  always_ff @(posedge clk) begin
    if (bq_push) q[wp] <= bq_data;
  end

  // Advance pointers and the result select
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      idx <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (bq_push) wp <= ~wp;
      if (pop)     rp <= ~rp;
      if (xfer)    idx <= !res_last;
      cnt <= cnt + 2'(bq_push) - 2'(pop);
    end
  end

endmodule

// ----- src/i2c_eeprom_master_sequencer_unit.sv -----
`timescale 1ns / 1ps
// I2C EEPROM master sequencer, top level. An input transfer reaches the first result
// through the front queue, then the output queue; the sequencer is combinational.
// Throughput: one item per cycle while out_ready stays high; an item with two results
// holds the output until both of its results are transferred.
// Reset (rst, synchronous): idle phase, empty queues, select byte 0xA6.
// Depends on i2cems_pkg, i2cems_front, i2cems_seq and i2cems_out.
module i2c_eeprom_master_sequencer_unit import i2cems_pkg::*; #(
  parameter int unsigned BANK_SIZE   = DEF_BANK_SIZE,
  parameter int unsigned PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int unsigned RETRY_LIMIT = DEF_RETRY_LIMIT,
  parameter int unsigned MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [16:0] address,
  input  logic [10:0] length,
  input  logic [7:0]  bus_status,
  input  logic [7:0]  bus_byte,
  input  logic [7:0]  write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  bus_action,
  output logic [7:0]  tx_byte,
  output logic [7:0]  rx_byte,
  output logic        rx_valid,
  output logic        done_res,
  output logic        failed,
  output logic [10:0] byte_count,
  output logic        last
);

  logic    item_valid, item_ready;
  item_t   item;
  logic    bq_push, bq_full;
  bundle_t bq_data;
  result_t res;

  i2cems_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .address, .length,
    .bus_status, .bus_byte, .write_byte, .item_valid, .item_ready, .item
  );

  i2cems_seq #(
    .BANK_SIZE(BANK_SIZE), .PAGE_BYTES(PAGE_BYTES), .RETRY_LIMIT(RETRY_LIMIT)
  ) u_seq (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .item_valid, .item_ready, .item,
    .bq_push, .bq_full, .bq_data
  );

  i2cems_out u_out (
    .clk, .rst, .bq_push, .bq_full, .bq_data, .out_valid, .out_ready,
    .res, .res_last(last)
  );

  assign bus_action = res.bus_action;
  assign tx_byte    = res.tx_byte;
  assign rx_byte    = res.rx_byte;
  assign rx_valid   = res.rx_valid;
  assign done_res   = res.done_res;
  assign failed     = res.failed;
  assign byte_count = res.byte_count;

`ifndef SYNTHESIS
  a_fail_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> done_res) else $error("failure without done");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last) else $error("done result not last");
  a_rx_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> (bus_action == ACT_RX_ACK || bus_action == ACT_RX_NACK ||
                               bus_action == ACT_STOP))
    else $error("read byte on wrong action");
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_action != ACT_SEND |-> tx_byte == 8'd0)
    else $error("send byte on non-send action");
`endif

endmodule

// ----- tb/sv/i2c_eeprom_master_sequencer_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the I2C EEPROM master sequencer: directed table, then random
// request and bus-event streams checked against a behavioural predictor.
// Depends on i2cems_pkg and i2c_eeprom_master_sequencer_unit.
module i2c_eeprom_master_sequencer_unit_test;
  import i2cems_pkg::*;

  localparam int unsigned BANK  = DEF_BANK_SIZE;
  localparam int unsigned PAGE  = DEF_PAGE_BYTES;
  localparam int unsigned RETRY = DEF_RETRY_LIMIT;
  localparam int unsigned MAXL  = DEF_MAX_LENGTH;
  localparam int unsigned N_RANDOM = 920;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef enum int {
    PH_IDLE, PH_START, PH_SLA_W, PH_ADDR_HI, PH_ADDR_LO, PH_RSTART, PH_SLA_R,
    PH_RDATA, PH_WDATA
  } seq_phase_t;

  typedef struct {
    logic [1:0]  req;
    logic [16:0] addr;
    logic [10:0] len;
    logic [7:0]  st;
    logic [7:0]  rxb;
    logic [7:0]  wb;
  } bus_item_t;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  tx;
    logic [7:0]  rxb;
    logic        rxv;
    logic        done;
    logic        fail;
    logic [10:0] cnt;
    logic        lst;
  } bus_result_t;

  // Directed row: item plus an optional hand-written first result
  typedef struct {
    bus_item_t   item;
    logic        known;
    bus_result_t res;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [16:0] address = '0;
  logic [10:0] length = '0;
  logic [7:0]  bus_status = '0;
  logic [7:0]  bus_byte = '0;
  logic [7:0]  write_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  bus_action;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic        done_res;
  logic        failed;
  logic [10:0] byte_count;
  logic        last;

  i2c_eeprom_master_sequencer_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .address(address),
    .length(length), .bus_status(bus_status), .bus_byte(bus_byte),
    .write_byte(write_byte), .out_valid(out_valid), .out_ready(out_ready),
    .bus_action(bus_action), .tx_byte(tx_byte), .rx_byte(rx_byte), .rx_valid(rx_valid),
    .done_res(done_res), .failed(failed), .byte_count(byte_count), .last(last)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [7:0]  sel_byte;
  seq_phase_t  ph;
  logic        wr_mode;
  int unsigned cur_addr, remain, chunk, retries, moved;

  bus_result_t expected_q[$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit          quiet_rx = 1'b0;   // no random stall on the receiver
  bit          quiet_tx = 1'b0;
  bit          rx_hold = 1'b0;
  int unsigned hold_left = 0;

  function automatic bus_result_t mk(logic [2:0] a, logic [7:0] t, logic [7:0] r,
                                     logic v, logic d, logic f);
    bus_result_t x;
    x.act = a; x.tx = t; x.rxb = r; x.rxv = v; x.done = d; x.fail = f;
    x.cnt = moved[10:0]; x.lst = 1'b0;
    return x;
  endfunction

  function automatic int unsigned bank_offset();
    return (cur_addr >= BANK) ? cur_addr - BANK : cur_addr;
  endfunction

  function automatic logic [7:0] select_for(logic rd);
    logic [7:0] s;
    s = sel_byte & ~8'h09;
    if (cur_addr >= BANK) s = s | 8'h08;
    return s | {7'd0, rd};
  endfunction

  function automatic void open_part();
    int unsigned c, room;
    c = remain;
    if (wr_mode) begin
      room = PAGE - bank_offset() % PAGE;
      if (room < c) c = room;
    end else if (cur_addr < BANK && cur_addr + remain > BANK) begin
      c = BANK - cur_addr;
    end
    chunk = c;
    retries = 1;
    ph = PH_START;
  endfunction

  function automatic bus_result_t abort_stop();
    ph = PH_IDLE;
    return mk(ACT_STOP, 0, 0, 0, 1, 1);
  endfunction

  // Close a part; a second result opens the next one
  function automatic void close_part(ref bus_result_t o[$], input logic [7:0] r,
                                     input logic v);
    cur_addr = (cur_addr + chunk) & 32'h1FFFF;
    remain = (remain - chunk) & 32'h7FF;
    chunk = 0;
    if (remain == 0) begin
      ph = PH_IDLE;
      o.push_back(mk(ACT_STOP, 0, r, v, 1, 0));
    end else begin
      o.push_back(mk(ACT_STOP, 0, r, v, 0, 0));
      open_part();
      o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
    end
  endfunction

  function automatic void advance_on_status(ref bus_result_t o[$], input bus_item_t it);
    bit fallthrough;
    fallthrough = 1'b0;
    case (ph)
      PH_START:
        if (it.st == ST_START || it.st == ST_REP_START) begin
          ph = PH_SLA_W; o.push_back(mk(ACT_SEND, select_for(0), 0, 0, 0, 0));
        end else if (it.st == ST_ARB_LOST) begin
          o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
        end else begin
          ph = PH_IDLE; o.push_back(mk(ACT_NONE, 0, 0, 0, 1, 1));
        end
      PH_SLA_W:
        if (it.st == ST_MT_SLA_ACK) begin
          ph = PH_ADDR_HI;
          o.push_back(mk(ACT_SEND, 8'(bank_offset() >> 8), 0, 0, 0, 0));
        end else if (it.st == ST_MT_SLA_NACK) begin
          if (retries >= RETRY) o.push_back(abort_stop());
          else begin
            retries++; ph = PH_START; o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
          end
        end else fallthrough = 1'b1;
      PH_ADDR_HI:
        if (it.st == ST_MT_DATA_ACK) begin
          ph = PH_ADDR_LO; o.push_back(mk(ACT_SEND, 8'(bank_offset()), 0, 0, 0, 0));
        end else if (it.st == ST_MT_DATA_NACK) begin
          if (wr_mode) o.push_back(abort_stop());
          else begin
            ph = PH_START; o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
          end
        end else fallthrough = 1'b1;
      PH_ADDR_LO:
        if (it.st == ST_MT_DATA_ACK) begin
          if (wr_mode) begin
            ph = PH_WDATA; o.push_back(mk(ACT_SEND, it.wb, 0, 0, 0, 0));
          end else begin
            ph = PH_RSTART; o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
          end
        end else if (it.st == ST_MT_DATA_NACK) begin
          if (wr_mode) o.push_back(abort_stop());
          else close_part(o, 0, 0);
        end else fallthrough = 1'b1;
      PH_RSTART:
        if (it.st == ST_START || it.st == ST_REP_START) begin
          ph = PH_SLA_R; o.push_back(mk(ACT_SEND, select_for(1), 0, 0, 0, 0));
        end else fallthrough = 1'b1;
      PH_SLA_R:
        if (it.st == ST_MR_SLA_ACK) begin
          ph = PH_RDATA;
          o.push_back(mk(chunk > 1 ? ACT_RX_ACK : ACT_RX_NACK, 0, 0, 0, 0, 0));
        end else if (it.st == ST_MR_SLA_NACK) close_part(o, 0, 0);
        else fallthrough = 1'b1;
      PH_RDATA:
        if (it.st == ST_MR_DATA_ACK || it.st == ST_MR_DATA_NACK) begin
          moved = (moved + 1) & 32'h7FF;
          cur_addr = (cur_addr + 1) & 32'h1FFFF;
          if (remain > 0) remain--;
          if (chunk > 0) chunk--;
          if (it.st == ST_MR_DATA_NACK || chunk == 0) close_part(o, it.rxb, 1);
          else o.push_back(mk(chunk > 1 ? ACT_RX_ACK : ACT_RX_NACK, 0, it.rxb, 1, 0, 0));
        end else o.push_back(abort_stop());
      PH_WDATA:
        if (it.st == ST_MT_DATA_ACK) begin
          moved = (moved + 1) & 32'h7FF;
          cur_addr = (cur_addr + 1) & 32'h1FFFF;
          if (remain > 0) remain--;
          if (chunk > 0) chunk--;
          if (chunk == 0) close_part(o, 0, 0);
          else o.push_back(mk(ACT_SEND, it.wb, 0, 0, 0, 0));
        end else o.push_back(abort_stop());
      default: ;
    endcase
    if (fallthrough) begin
      if (it.st == ST_ARB_LOST) begin
        ph = PH_START; o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
      end else o.push_back(abort_stop());
    end
  endfunction

  // Results one accepted item causes, with the last one marked
  function automatic void predict_results(input bus_item_t it, ref bus_result_t o[$]);
    if (it.req == REQ_READ || it.req == REQ_WRITE) begin
      if (ph == PH_IDLE) begin
        wr_mode = (it.req == REQ_WRITE);
        cur_addr = it.addr;
        moved = 0; chunk = 0; retries = 0;
        if (it.len == 0 || it.len > MAXL) begin
          remain = 0; o.push_back(mk(ACT_NONE, 0, 0, 0, 1, 1));
        end else begin
          remain = it.len; open_part(); o.push_back(mk(ACT_START, 0, 0, 0, 0, 0));
        end
      end
    end else if (it.req == REQ_STATUS && ph != PH_IDLE) begin
      advance_on_status(o, it);
    end
    if (o.size() > 0) o[o.size() - 1].lst = 1'b1;
  endfunction

  function automatic void reset_predictor();
    sel_byte = DEV_SEL_RESET; ph = PH_IDLE; wr_mode = 0;
    cur_addr = 0; remain = 0; chunk = 0; retries = 0; moved = 0;
  endfunction

  // Count cycles and abort on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** i2c_eeprom_master_sequencer_unit: FAILED **");
      $finish;
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    bus_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result act=%0d at cycle %0d",
                                       bus_action, cycles);
      end else begin
        e = expected_q.pop_front();
        if (bus_action !== e.act || tx_byte !== e.tx || rx_byte !== e.rxb ||
            rx_valid !== e.rxv || done_res !== e.done || failed !== e.fail ||
            byte_count !== e.cnt || last !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp act%0d tx%h rx%h v%b d%b f%b n%0d l%b / got act%0d tx%h rx%h v%b d%b f%b n%0d l%b",
                     e.act, e.tx, e.rxb, e.rxv, e.done, e.fail, e.cnt, e.lst,
                     bus_action, tx_byte, rx_byte, rx_valid, done_res, failed,
                     byte_count, last);
        end
      end
    end
  end

  // Receiver ready: random stalls, a quiet stretch, and a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
      if (hold_left == 0) rx_hold <= 1'b0;
      else hold_left <= hold_left - 1;
    end else begin
      out_ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  // Offer one item and hold it until transferred; predict on transfer.
  // Valid stays high afterwards so the next item can follow straight on.
  task automatic send_item(input bus_item_t it);
    bus_result_t got[$];
    while (!quiet_tx && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req_type <= it.req; address <= it.addr; length <= it.len;
    bus_status <= it.st; bus_byte <= it.rxb; write_byte <= it.wb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_results(it, got);
    foreach (got[i]) expected_q.push_back(got[i]);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_select(input logic [7:0] v);
    cfg_wr_data <= v; cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sel_byte = v;
  endtask

  function automatic bus_item_t mk_item(logic [1:0] r, int unsigned a, int unsigned l,
                                        logic [7:0] s);
    bus_item_t it;
    it.req = r; it.addr = a[16:0]; it.len = l[10:0]; it.st = s;
    it.rxb = 8'($urandom); it.wb = 8'($urandom);
    return it;
  endfunction

  // Status the predictor's sequence wants next; a random wrong one now and then
  function automatic logic [7:0] good_status();
    case (ph)
      PH_START, PH_RSTART: return ($urandom_range(1)) ? ST_START : ST_REP_START;
      PH_SLA_W: return ST_MT_SLA_ACK;
      PH_ADDR_HI, PH_ADDR_LO, PH_WDATA: return ST_MT_DATA_ACK;
      PH_SLA_R: return ST_MR_SLA_ACK;
      PH_RDATA: return ST_MR_DATA_ACK;
      default: return ST_START;
    endcase
  endfunction

  function automatic logic [7:0] pick_status();
    int unsigned r;
    logic [7:0] odd[11];
    odd = '{ST_START, ST_REP_START, ST_MT_SLA_ACK, ST_MT_SLA_NACK, ST_MT_DATA_ACK,
            ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_ACK, ST_MR_SLA_NACK,
            ST_MR_DATA_ACK, ST_MR_DATA_NACK};
    r = $urandom_range(99);
    if (r < 88) return good_status();
    if (r < 97) return odd[$urandom_range(10)];
    return 8'($urandom);
  endfunction

  function automatic bus_item_t random_request();
    int unsigned a, l, k;
    k = $urandom_range(9);
    case (k)
      0: a = BANK - $urandom_range(8);
      1: a = $urandom_range(17'h1FFFF, 17'h1FFF0);
      2: a = $urandom;
      default: a = $urandom_range(2 * BANK - 1);
    endcase
    a = a & 32'h1FFFF;
    k = $urandom_range(49);
    if (k == 0) l = $urandom_range(2047, MAXL + 1);
    else if (k == 1) l = 0;
    else if (k == 2) l = MAXL;
    else l = $urandom_range(12, 1);
    return mk_item($urandom_range(1), a, l, 0);
  endfunction

  table_row_t rows[$];

  initial begin
    bus_item_t it;
    bus_result_t got[$];
    int unsigned sent;
    logic [7:0] sel_list[4];

    reset_predictor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows: extremes, bad lengths, ignored items, status paths up to the repeated start
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_START), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(2'd3, 0, 1, 0), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_READ, 17'h1FFFF, 0, 0), 1'b1,
                     mk(ACT_NONE, 0, 0, 0, 1, 1)});
    rows.push_back('{mk_item(REQ_WRITE, 0, 2047, 0), 1'b1, mk(ACT_NONE, 0, 0, 0, 1, 1)});
    rows.push_back('{mk_item(REQ_WRITE, 0, MAXL + 1, 0), 1'b1,
                     mk(ACT_NONE, 0, 0, 0, 1, 1)});
    // read across the bank boundary, with arbitration loss and address NACK
    rows.push_back('{mk_item(REQ_READ, BANK - 1, 2, 0), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_WRITE, 5, 5, 0), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_ARB_LOST), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_START), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_SLA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_DATA_NACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, 8'hFF), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    // write into the top of bank 1; address NACK fails
    rows.push_back('{mk_item(REQ_WRITE, 17'h1FFFF, MAXL, 0), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_REP_START), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_SLA_NACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_START), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_SLA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_DATA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_DATA_NACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    // read that gets a read-select NACK status in place of the repeated start and aborts
    rows.push_back('{mk_item(REQ_READ, 100, 3, 0), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_START), 1'b0, mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_SLA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_DATA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MT_DATA_ACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_item(REQ_STATUS, 0, 1, ST_MR_SLA_NACK), 1'b0,
                     mk(0, 0, 0, 0, 0, 0)});

    foreach (rows[i]) begin
      it = rows[i].item;
      if (rows[i].known) begin
        got.delete();
        // hand-typed row: compare action and fail flag of the first predicted result with the table entry
        begin
          seq_phase_t sp; int unsigned sa, sr, sc, sn, sm; logic sw;
          sp = ph; sa = cur_addr; sr = remain; sc = chunk; sn = retries; sm = moved;
          sw = wr_mode;
          predict_results(it, got);
          ph = sp; cur_addr = sa; remain = sr; chunk = sc; retries = sn; moved = sm;
          wr_mode = sw;
          if (got.size() == 0 || got[0].act !== rows[i].res.act ||
              got[0].fail !== rows[i].res.fail) begin
            mismatches++;
            $display("table row %0d disagrees with predictor", i);
          end
        end
      end
      send_item(it);
    end
    drain_results();

    // Random phases, each under its own select byte
    sel_list = '{8'h00, 8'hFF, 8'h5A, DEV_SEL_RESET};
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      write_select(sel_list[p]);
      quiet_rx = (p == 2);
      quiet_tx = (p == 2);
      if (p == 1) begin
        hold_left = 400; rx_hold = 1'b1;
      end
      while (sent < (p + 1) * N_RANDOM / 4) begin
        if (ph == PH_IDLE || $urandom_range(99) < 2) it = random_request();
        else it = mk_item(REQ_STATUS, $urandom, $urandom, pick_status());
        // retry runs: NACK the select repeatedly in a few parts
        if (ph == PH_SLA_W && p == 3 && retries < RETRY && $urandom_range(3) == 0)
          it.st = ST_MT_SLA_NACK;
        send_item(it);
        sent++;
        // sender pause until everything has come back
        if (sent == N_RANDOM / 8) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk);
        end
      end
      quiet_rx = 0; quiet_tx = 0;
      while (ph != PH_IDLE) begin
        send_item(mk_item(REQ_STATUS, 0, 1, 8'hFF));
      end
      drain_results();
    end

    // Full retry exhaustion on one write part
    write_select(8'h5A);
    send_item(mk_item(REQ_WRITE, 3, 2, 0));
    while (ph != PH_IDLE) begin
      send_item(mk_item(REQ_STATUS, 0, 1, (ph == PH_START) ? ST_START : ST_MT_SLA_NACK));
    end
    drain_results();

    if (mismatches == 0) begin
      $display("** i2c_eeprom_master_sequencer_unit: PASSED **");
    end else begin
      $display("** i2c_eeprom_master_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule
